// ===== rtl/core/utf8_codepoint_cell_width_core_defines.svh =====
// assertion macros for the utf8 cell width core
`ifndef UTF8_CODEPOINT_CELL_WIDTH_CORE_DEFINES_SVH
`define UTF8_CODEPOINT_CELL_WIDTH_CORE_DEFINES_SVH
// implication checked at every rising clock edge outside reset
`define U8CW_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication checked outside reset
`define U8CW_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== rtl/core/u8cw_pkg.sv =====
// shared types, constants and width lookup for the utf8 cell width core
package u8cw_pkg;
   localparam int unsigned CpWidth = 21;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic [2:0]         byte_count;
   } point_type;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic [2:0]         byte_count;
      logic [1:0]         cell_width;
   } result_type;

   typedef struct packed {
      logic [CpWidth-1:0] lo;
      logic [CpWidth-1:0] hi;
   } span_type;

   localparam int unsigned WideCount  = 121;
   localparam int unsigned AmbigCount = 179;

   localparam span_type WideRom [WideCount] = '{
      '{21'h01100,21'h0115f},'{21'h0231a,21'h0231b},'{21'h02329,21'h0232a},
      '{21'h023e9,21'h023ec},'{21'h023f0,21'h023f0},'{21'h023f3,21'h023f3},
      '{21'h025fd,21'h025fe},'{21'h02614,21'h02615},'{21'h02648,21'h02653},
      '{21'h0267f,21'h0267f},'{21'h02693,21'h02693},'{21'h026a1,21'h026a1},
      '{21'h026aa,21'h026ab},'{21'h026bd,21'h026be},'{21'h026c4,21'h026c5},
      '{21'h026ce,21'h026ce},'{21'h026d4,21'h026d4},'{21'h026ea,21'h026ea},
      '{21'h026f2,21'h026f3},'{21'h026f5,21'h026f5},'{21'h026fa,21'h026fa},
      '{21'h026fd,21'h026fd},'{21'h02705,21'h02705},'{21'h0270a,21'h0270b},
      '{21'h02728,21'h02728},'{21'h0274c,21'h0274c},'{21'h0274e,21'h0274e},
      '{21'h02753,21'h02755},'{21'h02757,21'h02757},'{21'h02795,21'h02797},
      '{21'h027b0,21'h027b0},'{21'h027bf,21'h027bf},'{21'h02b1b,21'h02b1c},
      '{21'h02b50,21'h02b50},'{21'h02b55,21'h02b55},'{21'h02e80,21'h02e99},
      '{21'h02e9b,21'h02ef3},'{21'h02f00,21'h02fd5},'{21'h02ff0,21'h02ffb},
      '{21'h03000,21'h0303e},'{21'h03041,21'h03096},'{21'h03099,21'h030ff},
      '{21'h03105,21'h0312f},'{21'h03131,21'h0318e},'{21'h03190,21'h031e3},
      '{21'h031f0,21'h0321e},'{21'h03220,21'h03247},'{21'h03250,21'h04dbf},
      '{21'h04e00,21'h0a48c},'{21'h0a490,21'h0a4c6},'{21'h0a960,21'h0a97c},
      '{21'h0ac00,21'h0d7a3},'{21'h0f900,21'h0faff},'{21'h0fe10,21'h0fe19},
      '{21'h0fe30,21'h0fe52},'{21'h0fe54,21'h0fe66},'{21'h0fe68,21'h0fe6b},
      '{21'h0ff01,21'h0ff60},'{21'h0ffe0,21'h0ffe6},'{21'h16fe0,21'h16fe4},
      '{21'h16ff0,21'h16ff1},'{21'h17000,21'h187f7},'{21'h18800,21'h18cd5},
      '{21'h18d00,21'h18d08},'{21'h1aff0,21'h1aff3},'{21'h1aff5,21'h1affb},
      '{21'h1affd,21'h1affe},'{21'h1b000,21'h1b122},'{21'h1b132,21'h1b132},
      '{21'h1b150,21'h1b152},'{21'h1b155,21'h1b155},'{21'h1b164,21'h1b167},
      '{21'h1b170,21'h1b2fb},'{21'h1f004,21'h1f004},'{21'h1f0cf,21'h1f0cf},
      '{21'h1f18e,21'h1f18e},'{21'h1f191,21'h1f19a},'{21'h1f200,21'h1f202},
      '{21'h1f210,21'h1f23b},'{21'h1f240,21'h1f248},'{21'h1f250,21'h1f251},
      '{21'h1f260,21'h1f265},'{21'h1f300,21'h1f320},'{21'h1f32d,21'h1f335},
      '{21'h1f337,21'h1f37c},'{21'h1f37e,21'h1f393},'{21'h1f3a0,21'h1f3ca},
      '{21'h1f3cf,21'h1f3d3},'{21'h1f3e0,21'h1f3f0},'{21'h1f3f4,21'h1f3f4},
      '{21'h1f3f8,21'h1f43e},'{21'h1f440,21'h1f440},'{21'h1f442,21'h1f4fc},
      '{21'h1f4ff,21'h1f53d},'{21'h1f54b,21'h1f54e},'{21'h1f550,21'h1f567},
      '{21'h1f57a,21'h1f57a},'{21'h1f595,21'h1f596},'{21'h1f5a4,21'h1f5a4},
      '{21'h1f5fb,21'h1f64f},'{21'h1f680,21'h1f6c5},'{21'h1f6cc,21'h1f6cc},
      '{21'h1f6d0,21'h1f6d2},'{21'h1f6d5,21'h1f6d7},'{21'h1f6dc,21'h1f6df},
      '{21'h1f6eb,21'h1f6ec},'{21'h1f6f4,21'h1f6fc},'{21'h1f7e0,21'h1f7eb},
      '{21'h1f7f0,21'h1f7f0},'{21'h1f90c,21'h1f93a},'{21'h1f93c,21'h1f945},
      '{21'h1f947,21'h1f9ff},'{21'h1fa70,21'h1fa7c},'{21'h1fa80,21'h1fa88},
      '{21'h1fa90,21'h1fabd},'{21'h1fabf,21'h1fac5},'{21'h1face,21'h1fadb},
      '{21'h1fae0,21'h1fae8},'{21'h1faf0,21'h1faf8},'{21'h20000,21'h2fffd},
      '{21'h30000,21'h3fffd}
   };

   localparam span_type AmbigRom [AmbigCount] = '{
      '{21'h000a1,21'h000a1},'{21'h000a4,21'h000a4},'{21'h000a7,21'h000a8},
      '{21'h000aa,21'h000aa},'{21'h000ad,21'h000ae},'{21'h000b0,21'h000b4},
      '{21'h000b6,21'h000ba},'{21'h000bc,21'h000bf},'{21'h000c6,21'h000c6},
      '{21'h000d0,21'h000d0},'{21'h000d7,21'h000d8},'{21'h000de,21'h000e1},
      '{21'h000e6,21'h000e6},'{21'h000e8,21'h000ea},'{21'h000ec,21'h000ed},
      '{21'h000f0,21'h000f0},'{21'h000f2,21'h000f3},'{21'h000f7,21'h000fa},
      '{21'h000fc,21'h000fc},'{21'h000fe,21'h000fe},'{21'h00101,21'h00101},
      '{21'h00111,21'h00111},'{21'h00113,21'h00113},'{21'h0011b,21'h0011b},
      '{21'h00126,21'h00127},'{21'h0012b,21'h0012b},'{21'h00131,21'h00133},
      '{21'h00138,21'h00138},'{21'h0013f,21'h00142},'{21'h00144,21'h00144},
      '{21'h00148,21'h0014b},'{21'h0014d,21'h0014d},'{21'h00152,21'h00153},
      '{21'h00166,21'h00167},'{21'h0016b,21'h0016b},'{21'h001ce,21'h001ce},
      '{21'h001d0,21'h001d0},'{21'h001d2,21'h001d2},'{21'h001d4,21'h001d4},
      '{21'h001d6,21'h001d6},'{21'h001d8,21'h001d8},'{21'h001da,21'h001da},
      '{21'h001dc,21'h001dc},'{21'h00251,21'h00251},'{21'h00261,21'h00261},
      '{21'h002c4,21'h002c4},'{21'h002c7,21'h002c7},'{21'h002c9,21'h002cb},
      '{21'h002cd,21'h002cd},'{21'h002d0,21'h002d0},'{21'h002d8,21'h002db},
      '{21'h002dd,21'h002dd},'{21'h002df,21'h002df},'{21'h00300,21'h0036f},
      '{21'h00391,21'h003a1},'{21'h003a3,21'h003a9},'{21'h003b1,21'h003c1},
      '{21'h003c3,21'h003c9},'{21'h00401,21'h00401},'{21'h00410,21'h0044f},
      '{21'h00451,21'h00451},'{21'h02010,21'h02010},'{21'h02013,21'h02016},
      '{21'h02018,21'h02019},'{21'h0201c,21'h0201d},'{21'h02020,21'h02022},
      '{21'h02024,21'h02027},'{21'h02030,21'h02030},'{21'h02032,21'h02033},
      '{21'h02035,21'h02035},'{21'h0203b,21'h0203b},'{21'h0203e,21'h0203e},
      '{21'h02074,21'h02074},'{21'h0207f,21'h0207f},'{21'h02081,21'h02084},
      '{21'h020ac,21'h020ac},'{21'h02103,21'h02103},'{21'h02105,21'h02105},
      '{21'h02109,21'h02109},'{21'h02113,21'h02113},'{21'h02116,21'h02116},
      '{21'h02121,21'h02122},'{21'h02126,21'h02126},'{21'h0212b,21'h0212b},
      '{21'h02153,21'h02154},'{21'h0215b,21'h0215e},'{21'h02160,21'h0216b},
      '{21'h02170,21'h02179},'{21'h02189,21'h02189},'{21'h02190,21'h02199},
      '{21'h021b8,21'h021b9},'{21'h021d2,21'h021d2},'{21'h021d4,21'h021d4},
      '{21'h021e7,21'h021e7},'{21'h02200,21'h02200},'{21'h02202,21'h02203},
      '{21'h02207,21'h02208},'{21'h0220b,21'h0220b},'{21'h0220f,21'h0220f},
      '{21'h02211,21'h02211},'{21'h02215,21'h02215},'{21'h0221a,21'h0221a},
      '{21'h0221d,21'h02220},'{21'h02223,21'h02223},'{21'h02225,21'h02225},
      '{21'h02227,21'h0222c},'{21'h0222e,21'h0222e},'{21'h02234,21'h02237},
      '{21'h0223c,21'h0223d},'{21'h02248,21'h02248},'{21'h0224c,21'h0224c},
      '{21'h02252,21'h02252},'{21'h02260,21'h02261},'{21'h02264,21'h02267},
      '{21'h0226a,21'h0226b},'{21'h0226e,21'h0226f},'{21'h02282,21'h02283},
      '{21'h02286,21'h02287},'{21'h02295,21'h02295},'{21'h02299,21'h02299},
      '{21'h022a5,21'h022a5},'{21'h022bf,21'h022bf},'{21'h02312,21'h02312},
      '{21'h02460,21'h024e9},'{21'h024eb,21'h0254b},'{21'h02550,21'h02573},
      '{21'h02580,21'h0258f},'{21'h02592,21'h02595},'{21'h025a0,21'h025a1},
      '{21'h025a3,21'h025a9},'{21'h025b2,21'h025b3},'{21'h025b6,21'h025b7},
      '{21'h025bc,21'h025bd},'{21'h025c0,21'h025c1},'{21'h025c6,21'h025c8},
      '{21'h025cb,21'h025cb},'{21'h025ce,21'h025d1},'{21'h025e2,21'h025e5},
      '{21'h025ef,21'h025ef},'{21'h02605,21'h02606},'{21'h02609,21'h02609},
      '{21'h0260e,21'h0260f},'{21'h0261c,21'h0261c},'{21'h0261e,21'h0261e},
      '{21'h02640,21'h02640},'{21'h02642,21'h02642},'{21'h02660,21'h02661},
      '{21'h02663,21'h02665},'{21'h02667,21'h0266a},'{21'h0266c,21'h0266d},
      '{21'h0266f,21'h0266f},'{21'h0269e,21'h0269f},'{21'h026bf,21'h026bf},
      '{21'h026c6,21'h026cd},'{21'h026cf,21'h026d3},'{21'h026d5,21'h026e1},
      '{21'h026e3,21'h026e3},'{21'h026e8,21'h026e9},'{21'h026eb,21'h026f1},
      '{21'h026f4,21'h026f4},'{21'h026f6,21'h026f9},'{21'h026fb,21'h026fc},
      '{21'h026fe,21'h026ff},'{21'h0273d,21'h0273d},'{21'h02776,21'h0277f},
      '{21'h02b56,21'h02b59},'{21'h03248,21'h0324f},'{21'h0e000,21'h0f8ff},
      '{21'h0fe00,21'h0fe0f},'{21'h0fffd,21'h0fffd},'{21'h1f100,21'h1f10a},
      '{21'h1f110,21'h1f12d},'{21'h1f130,21'h1f169},'{21'h1f170,21'h1f18d},
      '{21'h1f18f,21'h1f190},'{21'h1f19b,21'h1f1ac},'{21'h0e0100,21'h0e01ef},
      '{21'h0f0000,21'h0ffffd},'{21'h100000,21'h10fffd}
   };
endpackage

// ===== rtl/core/u8cw_if.sv =====
// valid/ready channels: one carries an input byte, the other a result word
interface u8cw_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8cw_result_if;
   import u8cw_pkg::*;
   logic       valid;
   logic       ready;
   result_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/u8cw_decode.sv =====
// utf8 sequence assembler: collects bytes into a code point
module u8cw_decode import u8cw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] in_byte,
   output logic       done,
   output point_type  point
);
   logic [1:0]         left_ff, left_in;
   logic [CpWidth-1:0] part_ff, part_in;
   logic [2:0]         len_ff, len_in;

   always_comb begin
      left_in = left_ff;
      part_in = part_ff;
      len_in  = len_ff;
      done    = 1'b0;
      point.code_point = {{(CpWidth-8){1'b0}}, in_byte};
      point.byte_count = 3'd1;
      if (left_ff != 2'd0) begin
         part_in = {part_ff[CpWidth-7:0], in_byte[5:0]};
         left_in = left_ff - 2'd1;
         done    = (left_ff == 2'd1);
         point.code_point = part_in;
         point.byte_count = len_ff;
      end else begin
         priority if ((in_byte & 8'hf8) == 8'hf0) begin
            len_in = 3'd4; part_in = {{(CpWidth-3){1'b0}}, in_byte[2:0]}; left_in = 2'd3;
         end else if ((in_byte & 8'hf0) == 8'he0) begin
            len_in = 3'd3; part_in = {{(CpWidth-4){1'b0}}, in_byte[3:0]}; left_in = 2'd2;
         end else if ((in_byte & 8'he0) == 8'hc0) begin
            len_in = 3'd2; part_in = {{(CpWidth-5){1'b0}}, in_byte[4:0]}; left_in = 2'd1;
         end else begin
            len_in = 3'd1; part_in = {{(CpWidth-8){1'b0}}, in_byte};
            done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 2'd0;
         part_ff <= '0;
         len_ff  <= 3'd0;
      end else if (step) begin
         left_ff <= left_in;
         part_ff <= part_in;
         len_ff  <= len_in;
      end
   end
endmodule

// ===== rtl/core/u8cw_width.sv =====
// cell width lookup from parallel range compares
module u8cw_width import u8cw_pkg::*; (
   input  logic [CpWidth-1:0] code_point,
   output logic [1:0]         cell_width
);
   logic [WideCount-1:0]  wide_hit;
   logic [AmbigCount-1:0] ambig_hit;

   always_comb begin
      for (int i = 0; i < WideCount; i++)
         wide_hit[i] = (code_point >= WideRom[i].lo) && (code_point <= WideRom[i].hi);
      for (int j = 0; j < AmbigCount; j++)
         ambig_hit[j] = (code_point >= AmbigRom[j].lo) && (code_point <= AmbigRom[j].hi);
      // printable ascii is never in either rom, so the ors settle it
      cell_width = ((|wide_hit) || (|ambig_hit)) ? 2'd2 : 2'd1;
   end
endmodule

// ===== rtl/core/utf8_codepoint_cell_width_core.sv =====
// top level: utf8 decoder with terminal cell width per code point
// a code point appears on rsp in the cycle after its last byte is taken
// throughput: one byte per cycle, set by the single result register
// the input is held off only while a finished word waits and rsp is stalled
// reset (synchronous, active high) clears the open sequence and the result valid
// the width roms are parallel range compares in front of the result register
module utf8_codepoint_cell_width_core import u8cw_pkg::*; (
   input logic            clock,
   input logic            reset,
   u8cw_byte_if.sink      req,
   u8cw_result_if.source  rsp
);
`include "utf8_codepoint_cell_width_core_defines.svh"

   logic       take;
   logic       done;
   point_type  point;
   logic [1:0] width;
   logic       vld_ff;
   result_type res_ff;

   // result register frees up when empty or being taken this cycle
   assign req.ready = !vld_ff || rsp.ready;
   assign take      = req.valid && req.ready;

   u8cw_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (take),
      .in_byte (req.in_byte),
      .done    (done),
      .point   (point)
   );

   u8cw_width u_width (
      .code_point (point.code_point),
      .cell_width (width)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req.ready) begin
         vld_ff <= take && done;
      end
   end

   always_ff @(posedge clock) begin
      if (take && done) begin
         res_ff <= '{code_point: point.code_point, byte_count: point.byte_count,
                     cell_width: width};
      end
   end

   assign rsp.valid = vld_ff;
   assign rsp.data  = res_ff;

   // a stalled word holds until taken
   `U8CW_ASSERT_NXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data), "result word changed while stalled")
   // every delivered word has a legal count and width
   `U8CW_ASSERT_IMP(a_count, clock, reset, rsp.valid, rsp.data.byte_count >= 3'd1 && rsp.data.byte_count <= 3'd4, "bad byte count")
   `U8CW_ASSERT_IMP(a_width, clock, reset, rsp.valid, rsp.data.cell_width == 2'd1 || rsp.data.cell_width == 2'd2, "bad cell width")
   // no input is taken while a word is stalled
   `U8CW_ASSERT_IMP(a_stall, clock, reset, rsp.valid && !rsp.ready, !req.ready, "input taken over stalled word")
endmodule

// ===== dv/utf8_codepoint_cell_width_core_test.sv =====
// testbench for the utf8 decoder with terminal cell width
module utf8_codepoint_cell_width_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import u8cw_pkg::*;

   logic clock;
   logic reset;
   u8cw_byte_if   req_if ();
   u8cw_result_if rsp_if ();

   utf8_codepoint_cell_width_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   // predictor state, mirrors the decoder's open sequence
   logic [1:0]  pend_bytes;
   logic [20:0] accum_point;
   logic [2:0]  lead_length;
   result_type  expected_points[$];
   int          fail_count;
   int          send_idle_pct;
   int          take_idle_pct;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // true when the code point lies in one of the span lists
   function automatic logic in_spans(logic [20:0] cp, logic wide);
      int n;
      n = wide ? WideCount : AmbigCount;
      for (int i = 0; i < n; i++) begin
         if (wide) begin
            if (cp >= WideRom[i].lo && cp <= WideRom[i].hi) return 1'b1;
         end else begin
            if (cp >= AmbigRom[i].lo && cp <= AmbigRom[i].hi) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [1:0] cells_of(logic [20:0] cp);
      if (cp >= 21'h20 && cp <= 21'h7e) return 2'd1;
      if (in_spans(cp, 1'b1) || in_spans(cp, 1'b0)) return 2'd2;
      return 2'd1;
   endfunction

   // advance the decoder model by one byte, queue a code point when complete
   task automatic decode_byte(logic [7:0] b);
      result_type r;
      logic       done;
      done = 1'b0;
      if (pend_bytes != 2'd0) begin
         accum_point = {accum_point[14:0], b[5:0]};
         pend_bytes  = pend_bytes - 2'd1;
         if (pend_bytes == 2'd0) begin
            r.code_point = accum_point;
            r.byte_count = lead_length;
            done = 1'b1;
         end
      end else if (b[7:3] == 5'b11110) begin
         lead_length = 3'd4; accum_point = {18'd0, b[2:0]}; pend_bytes = 2'd3;
      end else if (b[7:4] == 4'b1110) begin
         lead_length = 3'd3; accum_point = {17'd0, b[3:0]}; pend_bytes = 2'd2;
      end else if (b[7:5] == 3'b110) begin
         lead_length = 3'd2; accum_point = {16'd0, b[4:0]}; pend_bytes = 2'd1;
      end else begin
         lead_length = 3'd1; accum_point = {13'd0, b};
         r.code_point = {13'd0, b};
         r.byte_count = 3'd1;
         done = 1'b1;
      end
      if (done) begin
         r.cell_width = cells_of(r.code_point);
         expected_points.push_back(r);
      end
   endtask

   // send one byte, with a random idle gap first
   task automatic send_byte(logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      decode_byte(b);
   endtask

   // encode a code point with the given length (overlong allowed)
   task automatic send_point(logic [20:0] cp, int len);
      case (len)
         1: send_byte(cp[7:0]);
         2: begin
            send_byte({3'b110, cp[10:6]});
            send_byte({2'b10, cp[5:0]});
         end
         3: begin
            send_byte({4'b1110, cp[15:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
         end
         default: begin
            send_byte({5'b11110, cp[20:18]});
            send_byte({2'b10, cp[17:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
         end
      endcase
   endtask

   // drop valid, then wait until every queued word has come back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   // extremes, every length and the odd bytes
   task automatic test_directed();
      send_point(21'h00, 1);        // nul, control width 1
      send_point(21'h1f, 1);
      send_point(21'h20, 1);
      send_point(21'h7e, 1);
      send_point(21'h7f, 1);
      send_byte(8'h80);             // stray continuation
      send_byte(8'hbf);
      send_byte(8'hf8);             // bytes above the four-byte lead
      send_byte(8'hff);
      send_point(21'h0a1, 2);       // ambiguous
      send_point(21'h7ff, 2);
      send_point(21'h1100, 3);      // wide
      send_point(21'hffff, 3);
      send_point(21'h10fffd, 4);
      send_point(21'h1fffff, 4);    // beyond unicode range
      send_point(21'h41, 3);        // overlong
      // new lead inside a sequence is taken as continuation
      send_byte(8'he4);
      send_byte(8'hf0);
      send_byte(8'hff);
      wait_drained();
   endtask

   task automatic test_random(int n);
      int kind;
      logic [20:0] cp;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(9);
         if (kind < 2) begin
            send_byte(8'($urandom_range(255)));
         end else begin
            case ($urandom_range(5))
               0: cp = 21'($urandom_range(21'h7ff));
               1: cp = 21'($urandom_range(21'h3fff, 21'h800));
               2: cp = 21'($urandom_range(21'hffff, 21'h4000));
               3: cp = 21'($urandom_range(21'h3ffff, 21'h10000));
               4: cp = 21'($urandom_range(21'h1fffff));
               default: cp = 21'($urandom_range(21'h1fff));
            endcase
            send_point(cp, $urandom_range(4, 1));
         end
         if (i == n / 2) wait_drained();  // sender pauses until all came back
      end
   endtask

   // receiver: random stall, compare each accepted word with the oldest one
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t unexpected word %h", $realtime, rsp_if.data);
               fail_count++;
            end else begin
               want = expected_points.pop_front();
               if (want !== rsp_if.data) begin
                  $display("%0t expected cp %h n %0d w %0d, got cp %h n %0d w %0d",
                     $realtime, want.code_point, want.byte_count, want.cell_width,
                     rsp_if.data.code_point, rsp_if.data.byte_count,
                     rsp_if.data.cell_width);
                  fail_count++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   initial begin
      #2000000;
      $display("utf8_codepoint_cell_width_core: mismatch");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.in_byte = 8'h00;
      pend_bytes     = 2'd0;
      accum_point    = 21'd0;
      lead_length    = 3'd0;
      fail_count     = 0;
      send_idle_pct  = 18;
      take_idle_pct  = 54;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(225);
      send_idle_pct = 54;
      take_idle_pct = 18;
      test_random(225);
      send_idle_pct = 0;
      take_idle_pct = 0;
      test_random(225);
      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_points.size() == 0)
         $display("utf8_codepoint_cell_width_core: match");
      else
         $display("utf8_codepoint_cell_width_core: mismatch");
      $finish;
   end
endmodule
